[hw/rtl/drop_oldest_packet_queue_core_defines.svh]
// assertion macros used by the queue controller
`ifndef DROP_OLDEST_PACKET_QUEUE_CORE_DEFINES_SVH
`define DROP_OLDEST_PACKET_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is held
`define DOPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define DOPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define DOPQ_ASSERT(lbl, prop, msg)
`define DOPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/dopq_pkg.sv]
// types and constants of the drop-oldest packet queue
package dopq_pkg;

  localparam int unsigned DOPQ_DEPTH = 64;
  localparam int unsigned OwnerW     = 16;
  localparam int unsigned HandleW    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_INV  = 2'd2
  } dopq_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAKE_RD,
    ST_TAKE_CHK,
    ST_PUSH_WR,
    ST_INV_RD,
    ST_INV_CHK,
    ST_PEEK_RD,
    ST_PEEK_CHK,
    ST_DONE
  } dopq_state_e;

  typedef struct packed {
    logic [OwnerW-1:0]  owner;
    logic [HandleW-1:0] handle;
  } dopq_entry_t;

  typedef struct packed {
    dopq_cmd_e          cmd;
    logic [OwnerW-1:0]  owner;
    logic [HandleW-1:0] handle;
  } dopq_req_t;

  typedef struct packed {
    logic               pop_valid;
    logic [OwnerW-1:0]  owner_out;
    logic [HandleW-1:0] handle_out;
    logic               dropped;
    logic [OwnerW-1:0]  peek_owner;
  } dopq_result_t;

endpackage

[hw/rtl/dopq_store.sv]
// entry memory: one write port, one registered read port
module dopq_store import dopq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DOPQ_DEPTH,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic        clk_i,
  input  logic [IW-1:0] addr_i,
  input  logic        we_i,
  input  dopq_entry_t wdata_i,
  output dopq_entry_t rdata_o
);

  dopq_entry_t mem_q [QUEUE_DEPTH];
  dopq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dopq_ctrl.sv]
// sequencer that walks the ring through one address adder and one owner compare
`include "drop_oldest_packet_queue_core_defines.svh"

module dopq_ctrl import dopq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DOPQ_DEPTH,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  dopq_req_t     req_i,
  output logic          busy_o,
  output logic [IW-1:0] mem_addr_o,
  output logic          mem_we_o,
  output dopq_entry_t   mem_wdata_o,
  input  dopq_entry_t   mem_rdata_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dopq_result_t  res_o,
  output logic [CW-1:0] occupancy_o,
  output logic [CW-1:0] high_water_o
);

  dopq_state_e state_q, state_d;

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] peak_q, peak_d;
  logic [CW-1:0] idx_q, idx_d;

  dopq_cmd_e          cmd_q, cmd_d;
  logic [OwnerW-1:0]  owner_q, owner_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic               pv_q, pv_d;
  logic [OwnerW-1:0]  po_q, po_d;
  logic [HandleW-1:0] ph_q, ph_d;
  logic               drop_q, drop_d;
  logic [OwnerW-1:0]  peek_q, peek_d;

  logic          full;
  logic [CW-1:0] offset;
  logic [OwnerW-1:0] cmp_key;
  logic          match;

  assign full = (count_q == CW'(QUEUE_DEPTH));

  // shared compare: against the invalidate owner, else against zero (invalidated)
  assign cmp_key = (state_q == ST_INV_CHK) ? owner_q : '0;
  assign match   = (mem_rdata_i.owner == cmp_key);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_i.cmd)
            CMD_PUSH: state_d = full ? ST_TAKE_RD : ST_PUSH_WR;
            CMD_POP:  state_d = ST_TAKE_RD;
            CMD_INV:  state_d = ST_INV_RD;
            default:  state_d = ST_PEEK_RD;
          endcase
        end
      end
      ST_TAKE_RD: begin
        if (count_q == '0) begin
          state_d = (cmd_q == CMD_PUSH) ? ST_PUSH_WR : ST_PEEK_RD;
        end else begin
          state_d = ST_TAKE_CHK;
        end
      end
      ST_TAKE_CHK: begin
        if (!match || count_q == CW'(1)) begin
          state_d = (cmd_q == CMD_PUSH) ? ST_PUSH_WR : ST_PEEK_RD;
        end else begin
          state_d = ST_TAKE_RD;
        end
      end
      ST_PUSH_WR:  state_d = ST_PEEK_RD;
      ST_INV_RD:   state_d = (idx_q == count_q) ? ST_PEEK_RD : ST_INV_CHK;
      ST_INV_CHK:  state_d = ST_INV_RD;
      ST_PEEK_RD:  state_d = (idx_q == count_q) ? ST_DONE : ST_PEEK_CHK;
      ST_PEEK_CHK: state_d = match ? ST_PEEK_RD : ST_DONE;
      ST_DONE:     state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    mem_we_o    = 1'b0;
    mem_wdata_o = '0;
    offset      = idx_q;
    case (state_q)
      ST_TAKE_RD, ST_TAKE_CHK: offset = '0;
      ST_PUSH_WR: begin
        offset      = count_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = '{owner: owner_q, handle: handle_q};
      end
      ST_INV_CHK: mem_we_o = match;
      default: ;
    endcase
    mem_addr_o = head_q + offset[IW-1:0];
  end

  // datapath
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    peak_d   = peak_q;
    idx_d    = idx_q;
    cmd_d    = cmd_q;
    owner_d  = owner_q;
    handle_d = handle_q;
    pv_d     = pv_q;
    po_d     = po_q;
    ph_d     = ph_q;
    drop_d   = drop_q;
    peek_d   = peek_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_d    = req_i.cmd;
          owner_d  = req_i.owner;
          handle_d = req_i.handle;
          pv_d     = 1'b0;
          po_d     = '0;
          ph_d     = '0;
          drop_d   = (req_i.cmd == CMD_PUSH) && full;
          idx_d    = '0;
        end
      end
      ST_TAKE_CHK: begin
        head_d  = head_q + IW'(1);
        count_d = count_q - CW'(1);
        if (!match && cmd_q == CMD_POP) begin
          pv_d = 1'b1;
          po_d = mem_rdata_i.owner;
          ph_d = mem_rdata_i.handle;
        end
      end
      ST_PUSH_WR: begin
        count_d = count_q + CW'(1);
        if (count_d > peak_q) begin
          peak_d = count_d;
        end
      end
      ST_INV_CHK: idx_d = idx_q + CW'(1);
      ST_PEEK_CHK: begin
        if (!match) begin
          peek_d = mem_rdata_i.owner;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
    // peek scan starts from the head
    if (state_d == ST_PEEK_RD && state_q != ST_PEEK_CHK) begin
      idx_d  = '0;
      peek_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    owner_q  <= owner_d;
    handle_q <= handle_d;
    pv_q     <= pv_d;
    po_q     <= po_d;
    ph_q     <= ph_d;
    drop_q   <= drop_d;
    peek_q   <= peek_d;
  end

  assign res_o = '{pop_valid:  pv_q,
                   owner_out:  po_q,
                   handle_out: ph_q,
                   dropped:    drop_q,
                   peek_owner: peek_q};
  assign occupancy_o  = count_q;
  assign high_water_o = peak_q;

  `DOPQ_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "occupancy above depth")
  `DOPQ_ASSERT(a_peak_covers, peak_q >= count_q, "high-water below occupancy")
  `DOPQ_ASSERT(a_push_grows, state_q == ST_PUSH_WR |=> count_q == $past(count_q) + CW'(1), "push did not grow the queue")
  `DOPQ_ASSERT(a_result_holds, (state_q == ST_DONE && !res_ready_i) |=> state_q == ST_DONE && $stable(res_o), "pending result lost")
  `DOPQ_ASSERT(a_drop_on_push, (res_valid_o && res_o.dropped) |-> cmd_q == CMD_PUSH, "drop flagged outside a push")

endmodule

[hw/rtl/drop_oldest_packet_queue_core.sv]
// drop-oldest packet queue: top level with the output register
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | cmd_i, owner_in_i, handle_in_i
//   out     | output    | out_valid_o / out_stall_i | pop_valid_o .. high_water_o
//
// entries are walked through the single memory read port and the shared owner compare,
// a read state and a check state per entry: push writes the entry, when full first
// dropping the oldest live entry with the invalidated ones ahead of it; pop removes up
// to the first live entry; invalidate clears entries of the given owner; then the peek
// scan skips invalidated entries up to the first valid one. the result is held while
// the output register is full and stalled, then ST_IDLE accepts the next transfer.
// reset clears state, head, count, high-water, out valid; no entry past the fill count
// is examined. a result waits in the output register under stall as the next step runs
module drop_oldest_packet_queue_core import dopq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DOPQ_DEPTH,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [OwnerW-1:0]  owner_in_i,
  input  logic [HandleW-1:0] handle_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pop_valid_o,
  output logic [OwnerW-1:0]  owner_out_o,
  output logic [HandleW-1:0] handle_out_o,
  output logic               dropped_o,
  output logic [OwnerW-1:0]  peek_owner_o,
  output logic [CW-1:0]      occupancy_o,
  output logic [CW-1:0]      high_water_o
);

  logic          busy;
  logic          req_valid;
  dopq_req_t     req;
  logic [IW-1:0] mem_addr;
  logic          mem_we;
  dopq_entry_t   mem_wdata;
  dopq_entry_t   mem_rdata;
  logic          res_valid;
  logic          res_ready;
  dopq_result_t  res;
  logic [CW-1:0] occ;
  logic [CW-1:0] hw;

  logic          out_valid_q, out_valid_d;
  dopq_result_t  res_q;
  logic [CW-1:0] occ_q;
  logic [CW-1:0] hw_q;
  logic          load;

  assign in_stall_o = busy;
  assign req_valid  = in_valid_i && !busy;
  assign req        = '{cmd: dopq_cmd_e'(cmd_i), owner: owner_in_i, handle: handle_in_i};

  dopq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .busy_o       (busy),
    .mem_addr_o   (mem_addr),
    .mem_we_o     (mem_we),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .occupancy_o  (occ),
    .high_water_o (hw)
  );

  dopq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output slot is free when empty or when its result transfers this cycle
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign load        = res_valid && res_ready;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
      occ_q <= occ;
      hw_q  <= hw;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pop_valid_o  = res_q.pop_valid;
  assign owner_out_o  = res_q.owner_out;
  assign handle_out_o = res_q.handle_out;
  assign dropped_o    = res_q.dropped;
  assign peek_owner_o = res_q.peek_owner;
  assign occupancy_o  = occ_q;
  assign high_water_o = hw_q;

endmodule

[tb/sv/tb_top.sv]
// testbench for the drop-oldest packet queue: predictor, checker and stimulus
`timescale 1ns / 1ps

package dopq_tb_pkg;
  import dopq_pkg::*;

  localparam logic [1:0]  CMD_RSVD = 2'd3;
  localparam int unsigned QDEPTH   = DOPQ_DEPTH;

  typedef struct packed {
    logic               pop_valid;
    logic [OwnerW-1:0]  owner_out;
    logic [HandleW-1:0] handle_out;
    logic               dropped;
    logic [OwnerW-1:0]  peek_owner;
    logic [6:0]         occupancy;
    logic [6:0]         high_water;
  } queue_status_t;

  class drop_queue_checker;
    dopq_entry_t   held[$];
    queue_status_t awaited_status[$];
    int unsigned   peak;
    int unsigned   errors;
    int unsigned   pushes, drops, pops_hit, invalidates, reserved;

    function new();
      peak = 0;
      errors = 0;
      pushes = 0;
      drops = 0;
      pops_hit = 0;
      invalidates = 0;
      reserved = 0;
    endfunction

    function int unsigned fill();
      return held.size();
    endfunction

    function int unsigned pending();
      return awaited_status.size();
    endfunction

    // pull entries off the head until a live one comes out
    function bit take_live(output dopq_entry_t got);
      dopq_entry_t e;
      got = '0;
      while (held.size() != 0) begin
        e = held.pop_front();
        if (e.owner != 0) begin
          got = e;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] op, logic [OwnerW-1:0] who,
                               logic [HandleW-1:0] hnd);
      queue_status_t s;
      dopq_entry_t   e;
      int            i;
      s = '0;
      case (op)
        CMD_PUSH: begin
          if (held.size() >= QDEPTH) begin
            s.dropped = 1'b1;
            drops++;
            void'(take_live(e));
          end
          e.owner  = who;
          e.handle = hnd;
          held.push_back(e);
          if (held.size() > peak) peak = held.size();
          pushes++;
        end
        CMD_POP: begin
          if (take_live(e)) begin
            s.pop_valid  = 1'b1;
            s.owner_out  = e.owner;
            s.handle_out = e.handle;
            pops_hit++;
          end
        end
        CMD_INV: begin
          foreach (held[k]) if (held[k].owner == who) held[k] = '0;
          invalidates++;
        end
        default: reserved++;
      endcase
      for (i = 0; i < held.size(); i++) begin
        if (held[i].owner != 0) begin
          s.peek_owner = held[i].owner;
          break;
        end
      end
      s.occupancy  = 7'(held.size());
      s.high_water = 7'(peak);
      awaited_status.push_back(s);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(queue_status_t seen);
      queue_status_t want;
      if (awaited_status.size() == 0) begin
        $error("result transfer with no pending expectation");
        errors++;
        return;
      end
      want = awaited_status.pop_front();
      compare_field("pop_valid", want.pop_valid, seen.pop_valid);
      compare_field("owner_out", want.owner_out, seen.owner_out);
      compare_field("handle_out", want.handle_out, seen.handle_out);
      compare_field("dropped", want.dropped, seen.dropped);
      compare_field("peek_owner", want.peek_owner, seen.peek_owner);
      compare_field("occupancy", want.occupancy, seen.occupancy);
      compare_field("high_water", want.high_water, seen.high_water);
    endfunction
  endclass

endpackage

module tb_top;
  import dopq_pkg::*;
  import dopq_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 1700;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [1:0]         cmd       = CMD_PUSH;
  logic [OwnerW-1:0]  owner_in  = '0;
  logic [HandleW-1:0] handle_in = '0;
  logic               out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic               pop_valid;
  logic [OwnerW-1:0]  owner_out;
  logic [HandleW-1:0] handle_out;
  logic               dropped;
  logic [OwnerW-1:0]  peek_owner;
  logic [6:0]         occupancy;
  logic [6:0]         high_water;

  drop_queue_checker tracker = new();
  queue_status_t     seen_status;

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;

  always #4 clk = ~clk;

  drop_oldest_packet_queue_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .owner_in_i   (owner_in),
    .handle_in_i  (handle_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pop_valid_o  (pop_valid),
    .owner_out_o  (owner_out),
    .handle_out_o (handle_out),
    .dropped_o    (dropped),
    .peek_owner_o (peek_owner),
    .occupancy_o  (occupancy),
    .high_water_o (high_water)
  );

  // result side: check every transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_status = {pop_valid, owner_out, handle_out, dropped, peek_owner,
                     occupancy, high_water};
      tracker.check_result(seen_status);
    end
  end

  // receiver stall pattern whose style is redrawn whenever its tick counter runs out
  always @(negedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_tick <= $urandom_range(50, 300);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick[1:0] != 2'd0);
    endcase
  end

  task automatic send_item(input logic [1:0] op, input logic [OwnerW-1:0] who,
                           input logic [HandleW-1:0] hnd);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    cmd       <= op;
    owner_in  <= who;
    handle_in <= hnd;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, who, hnd);
    items_sent++;
  endtask

  // hold off until the queue has answered everything sent so far
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // small pool of owners so that invalidates actually hit
  function automatic logic [OwnerW-1:0] pick_owner();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return OwnerW'($urandom_range(1, 6));
    if (r < 80) return '1;
    return OwnerW'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic push_random();
    send_item(CMD_PUSH, pick_owner(), $urandom);
  endtask

  initial begin
    int unsigned scenario;
    int unsigned len;
    int unsigned push_pct;
    int unsigned r;
    logic [OwnerW-1:0] victim;
    bit first_pass;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-queue corners, field extremes, invalidated entries
    send_item(CMD_POP, '0, '0);
    send_item(CMD_INV, '0, '0);
    send_item(CMD_RSVD, '0, '0);
    send_item(CMD_PUSH, '1, '1);
    send_item(CMD_PUSH, '0, 32'h1234_5678);
    send_item(CMD_PUSH, 16'd1, '0);
    send_item(CMD_INV, '0, '1);
    send_item(CMD_RSVD, '1, '1);
    send_item(CMD_INV, '1, '0);
    send_item(CMD_POP, '1, '1);
    send_item(CMD_POP, '0, '0);
    send_item(CMD_PUSH, '0, 32'hDEAD_BEEF);
    send_item(CMD_PUSH, '0, 32'h0BAD_F00D);
    send_item(CMD_POP, '0, '0);
    send_item(CMD_PUSH, 16'h8000, 32'h8000_0000);
    send_item(CMD_PUSH, 16'h7FFF, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 16'h8000, 32'h5555_5555);
    send_item(CMD_INV, 16'h8000, '0);
    send_item(CMD_POP, '0, '0);
    send_item(CMD_POP, '0, '0);

    first_pass = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (first_pass || $urandom_range(0, 5) == 0) wait_for_idle();
      first_pass = 1'b0;
      scenario = $urandom_range(0, 9);
      case (scenario)
        0, 1, 2, 3: begin
          len = $urandom_range(20, 80);
          push_pct = $urandom_range(30, 90);
          repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
              push_random();
            end else begin
              r = $urandom_range(0, 99);
              if (r < 85) send_item(CMD_POP, OwnerW'($urandom), $urandom);
              else if (r < 97) send_item(CMD_INV, pick_owner(), $urandom);
              else send_item(CMD_RSVD, OwnerW'($urandom), $urandom);
            end
          end
        end
        4, 5: begin
          // fill up, knock out one owner, then push past full
          while (tracker.fill() < QDEPTH) push_random();
          send_item(CMD_INV, OwnerW'($urandom_range(1, 6)), $urandom);
          repeat ($urandom_range(1, 20)) push_random();
        end
        6: begin
          // full queue where every pushed entry ends up invalidated
          victim = OwnerW'($urandom_range(1, 16'hFFFF));
          while (tracker.fill() < QDEPTH)
            send_item(CMD_PUSH, ($urandom_range(0, 2) == 0) ? '0 : victim, $urandom);
          send_item(CMD_INV, victim, $urandom);
          if ($urandom_range(0, 1) == 0) push_random();
          else send_item(CMD_POP, OwnerW'($urandom), $urandom);
          repeat ($urandom_range(1, 4)) push_random();
        end
        7, 8: begin
          repeat (tracker.fill() + $urandom_range(0, 3))
            send_item(CMD_POP, OwnerW'($urandom), $urandom);
        end
        default: begin
          repeat ($urandom_range(3, 10)) send_item(CMD_INV, pick_owner(), $urandom);
        end
      endcase
    end

    wait_for_idle();
    // give a stray extra result time to show up
    repeat (400) @(posedge clk);

    $display("covered %0d pushes (%0d dropping), %0d pops returning an entry, %0d invalidates,",
             tracker.pushes, tracker.drops, tracker.pops_hit, tracker.invalidates);
    $display("%0d reserved commands; queue high-water reached %0d of %0d entries",
             tracker.reserved, tracker.peak, QDEPTH);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
